// ===== sv/lcc_pkg.sv =====
// shared types and constants for the level crossing controller
package lcc_pkg;

    localparam int TimeWidth  = 32;
    localparam int CfgWidth   = 20;
    localparam int CodeWidth  = 3;
    localparam int IndexWidth = 2;

    // register indexes on the configuration port
    localparam logic [IndexWidth-1:0] CFG_APPROACH_TIMEOUT   = 2'd0;
    localparam logic [IndexWidth-1:0] CFG_LEAVE_CLEAR        = 2'd1;
    localparam logic [IndexWidth-1:0] CFG_GATE_CLOSE_TIMEOUT = 2'd2;

    localparam logic [CfgWidth-1:0] APPROACH_TIMEOUT_RESET   = 20'd10000;
    localparam logic [CfgWidth-1:0] LEAVE_CLEAR_RESET        = 20'd3000;
    localparam logic [CfgWidth-1:0] GATE_CLOSE_TIMEOUT_RESET = 20'd5000;

    // remote gate modes
    localparam logic [1:0] REMOTE_GATE_AUTO  = 2'd0;
    localparam logic [1:0] REMOTE_GATE_CLOSE = 2'd1;
    localparam logic [1:0] REMOTE_GATE_OPEN  = 2'd2;

    // remote warning overrides
    localparam logic [1:0] REMOTE_WARN_OFF  = 2'd0;
    localparam logic [1:0] REMOTE_WARN_ON   = 2'd1;
    localparam logic [1:0] REMOTE_WARN_AUTO = 2'd2;

    typedef struct packed {
        logic                 ir_approach;
        logic                 ir_inside;
        logic                 ir_leaving;
        logic                 limit_one;
        logic                 limit_two;
        logic                 ldr_dark;
        logic [1:0]           remote_gate;
        logic [1:0]           remote_warning;
        logic [TimeWidth-1:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic                 gate_closed;
        logic                 warnings_on;
        logic                 night_light;
        logic                 train_detected;
        logic [CodeWidth-1:0] crossing_code;
        logic                 fault_flag;
    } result_t;

    typedef struct packed {
        logic [CfgWidth-1:0] approach_timeout_ms;
        logic [CfgWidth-1:0] leave_clear_ms;
        logic [CfgWidth-1:0] gate_close_timeout_ms;
    } cfg_t;

endpackage

// ===== sv/lcc_if.sv =====
// request channel interfaces for control ticks and status results
interface lcc_tick_if
    import lcc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ir_approach;
    logic                 ir_inside;
    logic                 ir_leaving;
    logic                 limit_one;
    logic                 limit_two;
    logic                 ldr_dark;
    logic [1:0]           remote_gate;
    logic [1:0]           remote_warning;
    logic [TimeWidth-1:0] now_ms;

    modport source
    (
        output valid, ir_approach, ir_inside, ir_leaving, limit_one, limit_two,
               ldr_dark, remote_gate, remote_warning, now_ms,
        input  ready
    );
    modport sink
    (
        input  valid, ir_approach, ir_inside, ir_leaving, limit_one, limit_two,
               ldr_dark, remote_gate, remote_warning, now_ms,
        output ready
    );
endinterface

interface lcc_status_if
    import lcc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 gate_closed;
    logic                 warnings_on;
    logic                 night_light;
    logic                 train_detected;
    logic [CodeWidth-1:0] crossing_code;
    logic                 fault_flag;

    modport source
    (
        output valid, gate_closed, warnings_on, night_light, train_detected,
               crossing_code, fault_flag,
        input  ready
    );
    modport sink
    (
        input  valid, gate_closed, warnings_on, night_light, train_detected,
               crossing_code, fault_flag,
        output ready
    );
endinterface

// ===== sv/lcc_core.sv =====
// crossing state machine, timers and command logic
module lcc_core
    import lcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  tick_t   tick_data,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [CodeWidth-1:0] ST_IDLE     = 3'd0;
    localparam logic [CodeWidth-1:0] ST_APPROACH = 3'd1;
    localparam logic [CodeWidth-1:0] ST_INSIDE   = 3'd2;
    localparam logic [CodeWidth-1:0] ST_LEAVING  = 3'd3;
    localparam logic [CodeWidth-1:0] ST_FAULT    = 3'd4;

    localparam int PadWidth = TimeWidth - CfgWidth;

    logic [CodeWidth-1:0] state_reg, state_next, state_mid;
    logic [TimeWidth-1:0] approach_start_reg, approach_start_next;
    logic [TimeWidth-1:0] leave_start_reg, leave_start_next;
    logic [TimeWidth-1:0] gate_time_reg, gate_time_next;
    logic                 gate_cmd_reg, gate_cmd_next;
    logic                 fault_reg, fault_next;

    logic [TimeWidth-1:0] approach_elapsed, leave_elapsed, gate_elapsed;
    logic                 approach_expired, leave_expired, gate_expired;
    logic                 active, tgt_gate, tgt_warn, sw_closed, latch;

    assign approach_elapsed = tick_data.now_ms - approach_start_reg;
    assign leave_elapsed    = tick_data.now_ms - leave_start_reg;
    assign approach_expired = approach_elapsed > {{PadWidth{1'b0}}, cfg.approach_timeout_ms};
    assign leave_expired    = leave_elapsed > {{PadWidth{1'b0}}, cfg.leave_clear_ms};
    assign sw_closed        = tick_data.limit_one & tick_data.limit_two;

    always_comb
    begin
        state_mid           = state_reg;
        approach_start_next = approach_start_reg;
        leave_start_next    = leave_start_reg;
        if (fault_reg)
        begin
            state_mid = ST_FAULT;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (tick_data.ir_approach)
                    begin
                        state_mid           = ST_APPROACH;
                        approach_start_next = tick_data.now_ms;
                    end
                    else if (tick_data.ir_inside)
                    begin
                        state_mid = ST_INSIDE;
                    end
                end
                ST_APPROACH:
                begin
                    if (tick_data.ir_inside)
                        state_mid = ST_INSIDE;
                    else if (!tick_data.ir_approach && approach_expired)
                        state_mid = ST_IDLE;
                end
                ST_INSIDE:
                begin
                    if (tick_data.ir_leaving && !tick_data.ir_inside &&
                        !tick_data.ir_approach)
                    begin
                        state_mid        = ST_LEAVING;
                        leave_start_next = tick_data.now_ms;
                    end
                end
                ST_LEAVING:
                begin
                    if (!tick_data.ir_approach && !tick_data.ir_inside &&
                        !tick_data.ir_leaving && leave_expired)
                        state_mid = ST_IDLE;
                end
                default:
                begin
                    state_mid = state_reg;
                end
            endcase
        end
    end

    // remote overrides only apply with no train and no fault
    always_comb
    begin
        active   = (state_mid == ST_APPROACH) || (state_mid == ST_INSIDE) ||
                   (state_mid == ST_LEAVING);
        tgt_gate = active | fault_reg;
        tgt_warn = active | fault_reg;
        if (!active && !fault_reg)
        begin
            case (tick_data.remote_gate)
                REMOTE_GATE_CLOSE: tgt_gate = 1'b1;
                REMOTE_GATE_OPEN:  tgt_gate = 1'b0;
                default:           tgt_gate = 1'b0;
            endcase
            case (tick_data.remote_warning)
                REMOTE_WARN_ON:  tgt_warn = 1'b1;
                REMOTE_WARN_OFF: tgt_warn = 1'b0;
                default:         tgt_warn = 1'b0;
            endcase
        end
    end

    assign gate_time_next = (gate_cmd_reg != tgt_gate) ? tick_data.now_ms : gate_time_reg;
    assign gate_cmd_next  = tgt_gate;
    assign gate_elapsed   = tick_data.now_ms - gate_time_next;
    assign gate_expired   = gate_elapsed > {{PadWidth{1'b0}}, cfg.gate_close_timeout_ms};
    assign latch          = tgt_gate & ~sw_closed & gate_expired;
    assign fault_next     = fault_reg | latch;
    assign state_next     = latch ? ST_FAULT : state_mid;

    always_comb
    begin
        res.gate_closed    = tgt_gate;
        res.warnings_on    = tgt_warn;
        res.night_light    = tick_data.ldr_dark;
        res.train_detected = active;
        res.crossing_code  = state_next;
        res.fault_flag     = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            approach_start_reg <= '0;
            leave_start_reg    <= '0;
            gate_time_reg      <= '0;
            gate_cmd_reg       <= 1'b0;
            fault_reg          <= 1'b0;
        end
        else if (en)
        begin
            state_reg          <= state_next;
            approach_start_reg <= approach_start_next;
            leave_start_reg    <= leave_start_next;
            gate_time_reg      <= gate_time_next;
            gate_cmd_reg       <= gate_cmd_next;
            fault_reg          <= fault_next;
        end
    end

endmodule

// ===== sv/level_crossing_controller.sv =====
// level crossing controller top level: tick input stage, core and status register
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------------
//  tick     | in  | valid/ready  | detectors, limit switches, dark, remote modes, now_ms
//  status   | out | valid/ready  | gate, warnings, night light, train, code, fault
//  cfg      | in  | write enable | cfg_index selects one of three 20-bit timeouts
//
//  one tick request per cycle sustained while status is not stalled; a status request
//  is offered once its tick has passed the input register and then the status register
//  the crossing state updates as a tick moves from the input register into the
//  status register, so ticks follow back to back with no bubble
//  a stalled status register holds the input register; tick ready then drops
//  rst_n clears the state machine, timestamps, gate command and fault, and restores
//  the default timeouts
module level_crossing_controller
    import lcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lcc_tick_if.sink              tick,
    lcc_status_if.source          status,
    input  logic                  cfg_we,
    input  logic [IndexWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]   cfg_data
);

    // input register
    tick_t   tick_reg;
    logic    tick_valid_reg;

    // status register
    result_t res_reg;
    logic    res_valid_reg;

    cfg_t    cfg_reg;
    result_t res;
    tick_t   tick_in;
    logic    advance;

    // a tick moves on when the status register is free or being drained
    assign advance    = tick_valid_reg & (~res_valid_reg | status.ready);
    assign tick.ready = ~tick_valid_reg | advance;

    always_comb
    begin
        tick_in.ir_approach    = tick.ir_approach;
        tick_in.ir_inside      = tick.ir_inside;
        tick_in.ir_leaving     = tick.ir_leaving;
        tick_in.limit_one      = tick.limit_one;
        tick_in.limit_two      = tick.limit_two;
        tick_in.ldr_dark       = tick.ldr_dark;
        tick_in.remote_gate    = tick.remote_gate;
        tick_in.remote_warning = tick.remote_warning;
        tick_in.now_ms         = tick.now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
            tick_reg <= tick_in;
        if (advance)
            res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // timeout registers, writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.approach_timeout_ms   <= APPROACH_TIMEOUT_RESET;
            cfg_reg.leave_clear_ms        <= LEAVE_CLEAR_RESET;
            cfg_reg.gate_close_timeout_ms <= GATE_CLOSE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_APPROACH_TIMEOUT:   cfg_reg.approach_timeout_ms   <= cfg_data;
                CFG_LEAVE_CLEAR:        cfg_reg.leave_clear_ms        <= cfg_data;
                CFG_GATE_CLOSE_TIMEOUT: cfg_reg.gate_close_timeout_ms <= cfg_data;
                default:                ;
            endcase
        end
    end

    lcc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .tick_data (tick_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    assign status.valid          = res_valid_reg;
    assign status.gate_closed    = res_reg.gate_closed;
    assign status.warnings_on    = res_reg.warnings_on;
    assign status.night_light    = res_reg.night_light;
    assign status.train_detected = res_reg.train_detected;
    assign status.crossing_code  = res_reg.crossing_code;
    assign status.fault_flag     = res_reg.fault_flag;

endmodule
